>>> hdl/tfpr_pkg.sv
`timescale 1ns / 1ps

package tfpr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CW = 34;
    localparam int MAG_W = 31;
    localparam int ISQ_STEPS = 31;
    localparam int ISQ_W = 62;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        cw_t x;
        cw_t y;
        cw_t z;
    } cord_t;

    typedef struct packed {
        cord_t c;
        logic  flip;
        logic  zero;
    } fold_t;

    typedef struct packed {
        logic       valid;
        logic       pp;
        logic       rp;
        logic [1:0] flip;
        logic [1:0] zero;
    } sa_t;

    typedef struct packed {
        logic valid;
        logic pp;
        logic rp;
        logic level;
        mag_t cpa;
        mag_t spa;
        mag_t v;
    } sb_t;

    typedef struct packed {
        logic valid;
        logic pp;
        logic rp;
        logic level;
        mag_t cpa;
        mag_t spa;
        mag_t v;
        mag_t t;
        logic flip;
        logic zero;
    } sc_t;

    typedef struct packed {
        logic valid;
        logic pp;
        logic rp;
        logic level;
        mag_t t;
        mag_t zc;
    } sd_t;

    localparam cw_t ONE_Q30 = 34'sd1073741824;
    localparam cw_t GAIN_Q30 = 34'sd652032874;
    localparam mag_t MAG_ONE = 31'h4000_0000;
    localparam logic [16:0] DEG_K = 17'd93206;
    localparam logic [5:0] DEG_REM = 6'd34;
    localparam logic [4:0] DEG_RND = 5'd22;
    localparam logic [21:0] DEG_RECIP = 22'd2982617;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    function automatic cw_t atan_bam(input int i);
        cw_t r;
        unique case (i)
            0:       r = 34'sh20000000;
            1:       r = 34'sh12E4051E;
            2:       r = 34'sh09FB385B;
            3:       r = 34'sh051111D4;
            4:       r = 34'sh028B0D43;
            5:       r = 34'sh0145D7E1;
            6:       r = 34'sh00A2F61E;
            7:       r = 34'sh00517C55;
            8:       r = 34'sh0028BE53;
            9:       r = 34'sh00145F2F;
            10:      r = 34'sh000A2F98;
            11:      r = 34'sh000517CC;
            12:      r = 34'sh00028BE6;
            13:      r = 34'sh000145F3;
            14:      r = 34'sh0000A2F9;
            15:      r = 34'sh0000517D;
            16:      r = 34'sh000028BE;
            17:      r = 34'sh0000145F;
            18:      r = 34'sh00000A30;
            19:      r = 34'sh00000518;
            20:      r = 34'sh0000028C;
            21:      r = 34'sh00000146;
            22:      r = 34'sh000000A3;
            23:      r = 34'sh00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic cord_t rot_step(input cord_t c, input int i);
        cord_t r;
        cw_t   dx;
        cw_t   dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.z[CW-1])
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_bam(i);
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_bam(i);
        end
        return r;
    endfunction

    function automatic cord_t vec_step(input cord_t c, input int i);
        cord_t r;
        cw_t   dx;
        cw_t   dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.y > 0)
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_bam(i);
        end
        else
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_bam(i);
        end
        return r;
    endfunction

    // Folds a binary angle into [-90, 90) degrees for rotation.
    function automatic fold_t fold(input logic [31:0] a);
        fold_t       r;
        logic [31:0] a2;
        r.flip = a[31] ^ a[30];
        a2 = r.flip ? {~a[31], a[30:0]} : a;
        r.zero = (a2 == 32'd0);
        r.c.x = GAIN_Q30;
        r.c.y = '0;
        r.c.z = cw_t'(signed'(a2));
        return r;
    endfunction

    function automatic cw_t clamp_sym(input cw_t v);
        cw_t r;
        if (v > ONE_Q30)
            r = ONE_Q30;
        else if (v < -ONE_Q30)
            r = -ONE_Q30;
        else
            r = v;
        return r;
    endfunction

    function automatic mag_t clamp_pos(input cw_t v);
        mag_t r;
        if (v[CW-1])
            r = '0;
        else if (v > ONE_Q30)
            r = MAG_ONE;
        else
            r = v[MAG_W-1:0];
        return r;
    endfunction

    // Rotation result after the zero and fold corrections, clamped to +-1.
    function automatic cord_t rot_finish(input cord_t c, input logic flip, input logic zero);
        cord_t r;
        cw_t   x;
        cw_t   y;
        x = zero ? ONE_Q30 : c.x;
        y = zero ? '0 : c.y;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        r.x = clamp_sym(x);
        r.y = clamp_sym(y);
        r.z = '0;
        return r;
    endfunction

    function automatic mag_t abs_mag(input cw_t v);
        cw_t a;
        a = v[CW-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

>>> hdl/tilt_from_pitch_roll.sv
`timescale 1ns / 1ps
// Depth: 4*CORDIC_STAGES+48 register stages from input to output.
// Throughput: one transfer per cycle while the output is not stalled; every stage is a register with its own valid bit.
// The path is five CORDIC pipelines, a one-bit-per-stage square root and a few multiply stages.
// A stalled output holds the whole pipeline, so nothing is dropped or repeated.
// Reset clears all valid bits asynchronously, and the side-band structs with them; other data registers are not reset.
module tilt_from_pitch_roll (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pitch_deg [15:0], roll_deg [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // tilt_direction [15:0], tilt_angle [29:16], zero
    output logic [0:0]  m_axis_tuser   // level_flag [0]
);
    import tfpr_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic en;

    logic                s1_valid_reg;
    logic signed [15:0]  s1_ang_reg [2];

    logic                s2_valid_reg;
    logic                s2_pp_reg;
    logic                s2_rp_reg;
    logic                s2_neg_reg [2];
    logic [33:0]         s2_p1_reg [2];
    logic [42:0]         s2_p2_reg [2];

    logic                s3_valid_reg;
    logic                s3_pp_reg;
    logic                s3_rp_reg;
    logic [31:0]         s3_bam_reg [2];

    fold_t               sa_fold_next [2];
    sa_t                 sa_reg [N+1];
    cord_t               ra_reg [2][N+1];

    cord_t               f1_rot_next [2];
    sb_t                 f1_side_next;
    logic                f1_valid_reg;
    logic                f1_pp_reg;
    logic                f1_rp_reg;
    mag_t                f1_mag_reg [4];

    logic [61:0]         m1_prod_next;
    mag_t                m1_u_next;

    sb_t                 sb_reg [N+1];
    cord_t               va_reg [N+1];

    sb_t                 t_side_reg;
    mag_t                t_reg;

    fold_t               rb_fold_next;
    sc_t                 sc_reg [N+1];
    cord_t               rb_reg [N+1];

    cord_t               f2_rot_next;
    sc_t                 f2_side_reg;
    mag_t                f2_ct_reg;
    mag_t                f2_st_reg;

    logic [61:0]         m2_prod_next;
    sc_t                 m2_side_reg;
    mag_t                m2_ct_reg;
    mag_t                m2_yv_reg;

    sc_t                 m3_side_reg;
    logic [61:0]         m3_pa_reg;
    logic [61:0]         m3_pb_reg;

    logic [62:0]         zs_sum_next;
    mag_t                zs_z_next;
    sd_t                 zs_side_reg;

    logic [61:0]         sq_zz_next;
    sd_t                 sd_reg [ISQ_STEPS+1];
    logic [ISQ_W-1:0]    qn_reg [ISQ_STEPS+1];
    logic [ISQ_W-1:0]    qr_reg [ISQ_STEPS+1];

    sd_t                 se_reg [N+1];
    cord_t               vc_reg [N+1];

    mag_t                an_tq_next;
    logic                an_valid_reg;
    logic                an_level_reg;
    logic                an_neg_reg;
    logic [31:0]         an_dmag_reg;
    mag_t                an_ang_reg;

    logic                pr_valid_reg;
    logic                pr_level_reg;
    logic                pr_neg_reg;
    logic [62:0]         pr_pd_reg;
    logic [61:0]         pr_pz_reg;

    logic [62:0]         out_pd_next;
    logic [61:0]         out_pz_next;
    logic [15:0]         out_dq_next;
    logic                out_valid_reg;
    logic signed [15:0]  out_dir_reg;
    logic [13:0]         out_ang_reg;
    logic                out_level_reg;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ang_reg[0] <= s_axis_tdata[15:0];
            s1_ang_reg[1] <= s_axis_tdata[31:16];
        end
    end

    // Degrees to binary angle: round(|d| * 2^32 / 46080), split to stay exact.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pp_reg <= (s1_ang_reg[0] != 16'sd0) && !s1_ang_reg[0][15];
            s2_rp_reg <= (s1_ang_reg[1] != 16'sd0) && !s1_ang_reg[1][15];
            s3_pp_reg <= s2_pp_reg;
            s3_rp_reg <= s2_rp_reg;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_deg
        logic [16:0] ad_next;
        logic [20:0] w_next;
        logic [33:0] m_next;

        assign ad_next = s1_ang_reg[l][15] ? 17'(-17'(s1_ang_reg[l])) : 17'(s1_ang_reg[l]);
        assign w_next = 21'(ad_next * 21'(DEG_REM)) + 21'(DEG_RND);
        assign m_next = s2_p1_reg[l] + 34'(s2_p2_reg[l] >> 27);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_neg_reg[l] <= s1_ang_reg[l][15];
                s2_p1_reg[l] <= 34'(ad_next) * 34'(DEG_K);
                s2_p2_reg[l] <= 43'(w_next) * 43'(DEG_RECIP);
                s3_bam_reg[l] <= s2_neg_reg[l] ? 32'(-m_next) : m_next[31:0];
            end
        end
    end

    // Sine and cosine of pitch and roll.
    assign sa_fold_next[0] = fold(s3_bam_reg[0]);
    assign sa_fold_next[1] = fold(s3_bam_reg[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_reg[0] <= '0;
        else if (en)
        begin
            sa_reg[0].valid <= s3_valid_reg;
            sa_reg[0].pp <= s3_pp_reg;
            sa_reg[0].rp <= s3_rp_reg;
            sa_reg[0].flip <= {sa_fold_next[1].flip, sa_fold_next[0].flip};
            sa_reg[0].zero <= {sa_fold_next[1].zero, sa_fold_next[0].zero};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg[0][0] <= sa_fold_next[0].c;
            ra_reg[1][0] <= sa_fold_next[1].c;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_rot_a
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sa_reg[k+1] <= '0;
            else if (en)
                sa_reg[k+1] <= sa_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[0][k+1] <= rot_step(ra_reg[0][k], k);
                ra_reg[1][k+1] <= rot_step(ra_reg[1][k], k);
            end
        end
    end

    // Magnitudes: cos p, sin p, cos r, sin r.
    assign f1_rot_next[0] = rot_finish(ra_reg[0][N], sa_reg[N].flip[0], sa_reg[N].zero[0]);
    assign f1_rot_next[1] = rot_finish(ra_reg[1][N], sa_reg[N].flip[1], sa_reg[N].zero[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= sa_reg[N].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pp_reg <= sa_reg[N].pp;
            f1_rp_reg <= sa_reg[N].rp;
            f1_mag_reg[0] <= abs_mag(f1_rot_next[0].x);
            f1_mag_reg[1] <= abs_mag(f1_rot_next[0].y);
            f1_mag_reg[2] <= abs_mag(f1_rot_next[1].x);
            f1_mag_reg[3] <= abs_mag(f1_rot_next[1].y);
        end
    end

    // u = |sin p| |cos r|, v = |sin r|, then t = atan2(v, u).
    assign m1_prod_next = 62'(f1_mag_reg[1]) * 62'(f1_mag_reg[2]);
    assign m1_u_next = m1_prod_next[60:30];

    always_comb
    begin
        f1_side_next.valid = f1_valid_reg;
        f1_side_next.pp = f1_pp_reg;
        f1_side_next.rp = f1_rp_reg;
        f1_side_next.level = (m1_u_next == '0) && (f1_mag_reg[3] == '0);
        f1_side_next.cpa = f1_mag_reg[0];
        f1_side_next.spa = f1_mag_reg[1];
        f1_side_next.v = f1_mag_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_reg[0] <= '0;
        else if (en)
            sb_reg[0] <= f1_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg[0].x <= cw_t'(m1_u_next);
            va_reg[0].y <= cw_t'(f1_mag_reg[3]);
            va_reg[0].z <= '0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_vec_a
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sb_reg[k+1] <= '0;
            else if (en)
                sb_reg[k+1] <= sb_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                va_reg[k+1] <= vec_step(va_reg[k], k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_side_reg <= '0;
        else if (en)
            t_side_reg <= sb_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t_reg <= clamp_pos(va_reg[N].z);
    end

    // cos t and sin t.
    assign rb_fold_next = fold({1'b0, t_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_reg[0] <= '0;
        else if (en)
        begin
            sc_reg[0].valid <= t_side_reg.valid;
            sc_reg[0].pp <= t_side_reg.pp;
            sc_reg[0].rp <= t_side_reg.rp;
            sc_reg[0].level <= t_side_reg.level;
            sc_reg[0].cpa <= t_side_reg.cpa;
            sc_reg[0].spa <= t_side_reg.spa;
            sc_reg[0].v <= t_side_reg.v;
            sc_reg[0].t <= t_reg;
            sc_reg[0].flip <= rb_fold_next.flip;
            sc_reg[0].zero <= rb_fold_next.zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rb_reg[0] <= rb_fold_next.c;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_rot_b
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sc_reg[k+1] <= '0;
            else if (en)
                sc_reg[k+1] <= sc_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                rb_reg[k+1] <= rot_step(rb_reg[k], k);
        end
    end

    assign f2_rot_next = rot_finish(rb_reg[N], sc_reg[N].flip, sc_reg[N].zero);
    assign m2_prod_next = 62'(f2_st_reg) * 62'(f2_side_reg.v);
    assign zs_sum_next = 63'(m3_pa_reg) + 63'(m3_pb_reg);
    assign zs_z_next = (zs_sum_next[62:30] > 33'(MAG_ONE)) ? MAG_ONE : zs_sum_next[60:30];

    // y = sin t * v, then z = y |cos p| + cos t |sin p|, saturated to one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_side_reg <= '0;
            m2_side_reg <= '0;
            m3_side_reg <= '0;
            zs_side_reg <= '0;
        end
        else if (en)
        begin
            f2_side_reg <= sc_reg[N];
            m2_side_reg <= f2_side_reg;
            m3_side_reg <= m2_side_reg;
            zs_side_reg.valid <= m3_side_reg.valid;
            zs_side_reg.pp <= m3_side_reg.pp;
            zs_side_reg.rp <= m3_side_reg.rp;
            zs_side_reg.level <= m3_side_reg.level;
            zs_side_reg.t <= m3_side_reg.t;
            zs_side_reg.zc <= zs_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_ct_reg <= clamp_pos(f2_rot_next.x);
            f2_st_reg <= clamp_pos(f2_rot_next.y);
            m2_ct_reg <= f2_ct_reg;
            m2_yv_reg <= m2_prod_next[60:30];
            m3_pa_reg <= 62'(m2_yv_reg) * 62'(m2_side_reg.cpa);
            m3_pb_reg <= 62'(m2_ct_reg) * 62'(m2_side_reg.spa);
        end
    end

    // c = floor(sqrt(2^60 - z^2)), one result bit per stage.
    assign sq_zz_next = 62'(zs_side_reg.zc) * 62'(zs_side_reg.zc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sd_reg[0] <= '0;
        else if (en)
            sd_reg[0] <= zs_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qn_reg[0] <= (ISQ_W'(1) << 60) - sq_zz_next;
            qr_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_isqrt
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (60 - 2 * k);
        logic [ISQ_W-1:0] trial_next;

        assign trial_next = qr_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sd_reg[k+1] <= '0;
            else if (en)
                sd_reg[k+1] <= sd_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (qn_reg[k] >= trial_next)
                begin
                    qn_reg[k+1] <= qn_reg[k] - trial_next;
                    qr_reg[k+1] <= (qr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    qn_reg[k+1] <= qn_reg[k];
                    qr_reg[k+1] <= qr_reg[k] >> 1;
                end
            end
        end
    end

    // Tilt magnitude asin(z) = atan2(z, c).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_reg[0] <= '0;
        else if (en)
            se_reg[0] <= sd_reg[ISQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vc_reg[0].x <= cw_t'(qr_reg[ISQ_STEPS][MAG_W-1:0]);
            vc_reg[0].y <= cw_t'(sd_reg[ISQ_STEPS].zc);
            vc_reg[0].z <= '0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_vec_c
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                se_reg[k+1] <= '0;
            else if (en)
                se_reg[k+1] <= se_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                vc_reg[k+1] <= vec_step(vc_reg[k], k);
        end
    end

    // Direction is acos(x) = quarter turn - t, placed by the input signs.
    assign an_tq_next = MAG_ONE - se_reg[N].t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            an_valid_reg <= se_reg[N].valid;
            pr_valid_reg <= an_valid_reg;
            out_valid_reg <= pr_valid_reg;
        end
    end

    assign out_pd_next = pr_pd_reg + (63'(1) << 46);
    assign out_pz_next = pr_pz_reg + (62'(1) << 46);
    assign out_dq_next = out_pd_next[62:47];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_level_reg <= se_reg[N].level;
            an_neg_reg <= se_reg[N].pp;
            an_dmag_reg <= se_reg[N].rp ? (32'h8000_0000 - 32'(an_tq_next)) : 32'(an_tq_next);
            an_ang_reg <= clamp_pos(vc_reg[N].z);
            pr_level_reg <= an_level_reg;
            pr_neg_reg <= an_neg_reg;
            pr_pd_reg <= 63'(an_dmag_reg) * 63'(PI_Q29);
            pr_pz_reg <= 62'(an_ang_reg) * 62'(PI_Q29);
            out_level_reg <= pr_level_reg;
            if (pr_level_reg)
            begin
                out_dir_reg <= '0;
                out_ang_reg <= '0;
            end
            else
            begin
                out_dir_reg <= pr_neg_reg ? -out_dq_next : out_dq_next;
                out_ang_reg <= out_pz_next[60:47];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, out_ang_reg, out_dir_reg};
    assign m_axis_tuser = out_level_reg;

    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_level_reg |-> out_dir_reg == 16'sd0 && out_ang_reg == 14'd0)
        else $error("level result carries a nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_ang_reg <= 14'd12868)
        else $error("tilt angle beyond a quarter turn");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_dir_reg <= 16'sd25736 && out_dir_reg >= -16'sd25736)
        else $error("tilt direction beyond a half turn");

endmodule

>>> verif/tb_tilt_from_pitch_roll.sv
`timescale 1ns / 1ps

module tb_tilt_from_pitch_roll;

    localparam int STAGES = 16;
    localparam int LATENCY = 4 * STAGES + 48;
    localparam longint ONE = 64'sd1073741824;
    localparam longint QTR = 64'sd1073741824;
    localparam longint HALF = 64'sd2147483648;
    localparam longint GAIN = 64'sd652032874;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } angles_t;

    typedef struct {
        logic signed [15:0] direction;
        logic [13:0]        magnitude;
        logic               level;
    } tilt_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    angles_t pending_angles[$];
    tilt_t   expected_tilts[$];
    int      mismatches;
    longint  cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_output;

    tilt_from_pitch_roll uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic longint atan_table(input int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sin_cos(input logic [31:0] a, output longint c,
                                    output longint s);
        bit     flip;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        flip = a[31] ^ a[30];
        if (flip)
            a = a - 32'h80000000;
        z = longint'(signed'(a));
        if (z == 0)
        begin
            x = ONE;
            y = 0;
        end
        else
        begin
            x = GAIN;
            y = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_table(i);
                end
                else
                begin
                    x += dx; y -= dy; z += atan_table(i);
                end
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clampl(x, -ONE, ONE);
        s = clampl(y, -ONE, ONE);
    endfunction

    function automatic longint atan2_bam(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_table(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_table(i);
            end
        end
        return clampl(z, 0, QTR);
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [31:0] degrees_to_bam(input logic signed [15:0] d);
        longint unsigned m;
        m = (longint'(absl(d)) * 64'd4294967296 + 64'd23040) / 64'd46080;
        if (d < 0)
            m = -m;
        return m[31:0];
    endfunction

    function automatic longint unsigned bam_to_radians(input longint b);
        return (longint'(absl(b)) * 64'd1686629713 + (64'd1 << 46)) >> 47;
    endfunction

    function automatic tilt_t predict_tilt(input angles_t a);
        tilt_t  r;
        bit     pp;
        bit     rp;
        longint cp, sp, cr, sr, u, v, t, ct, st, y, z, c, dir;
        longint unsigned dq;
        pp = a.pitch > 0;
        rp = a.roll > 0;
        sin_cos(degrees_to_bam(a.pitch), cp, sp);
        sin_cos(degrees_to_bam(a.roll), cr, sr);
        u = (absl(sp) * absl(cr)) >>> 30;
        v = absl(sr);
        if (u == 0 && v == 0)
        begin
            r.direction = '0;
            r.magnitude = '0;
            r.level = 1'b1;
            return r;
        end
        t = atan2_bam(u, v);
        sin_cos(t[31:0], ct, st);
        ct = clampl(ct, 0, ONE);
        st = clampl(st, 0, ONE);
        y = (st * v) >>> 30;
        z = clampl((y * absl(cp) + ct * absl(sp)) >>> 30, 0, ONE);
        c = int_sqrt((64'd1 << 60) - z * z);
        z = atan2_bam(c, z);
        t = QTR - t;
        if (!pp && !rp)
            dir = t;
        else if (!pp && rp)
            dir = HALF - t;
        else if (pp && rp)
            dir = t - HALF;
        else
            dir = -t;
        dq = bam_to_radians(dir);
        r.direction = dir < 0 ? 16'(-dq) : 16'(dq);
        r.magnitude = 14'(bam_to_radians(z));
        r.level = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    task automatic queue_angles(input logic signed [15:0] p, input logic signed [15:0] r);
        angles_t a;
        a.pitch = p;
        a.roll = r;
        pending_angles.push_back(a);
    endtask

    function automatic logic signed [15:0] random_angle();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 16'($signed($urandom_range(0, 46080)) - 23040);
        else if (k < 80)
            return 16'($urandom);
        else if (k < 90)
            return 16'($signed($urandom_range(0, 6)) * 3840 - 11520 * 2);
        else
            return 16'($signed($urandom_range(0, 8)) - 4
                       + 128 * $signed($urandom_range(0, 4)) * 45 - 11520);
    endfunction

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tilt_from_pitch_roll verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_tilts.push_back(predict_tilt(angles_t'(s_axis_tdata)));
            if (pending_angles.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tdata <= pending_angles.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        tilt_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tilts.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 0);
            else
            begin
                w = expected_tilts.pop_front();
                if (m_axis_tdata[15:0] !== w.direction)
                    report_mismatch("tilt_direction", $signed(m_axis_tdata[15:0]), w.direction);
                if (m_axis_tdata[29:16] !== w.magnitude)
                    report_mismatch("tilt_angle", m_axis_tdata[29:16], w.magnitude);
                if (m_axis_tdata[31:30] !== 2'b00)
                    report_mismatch("padding", m_axis_tdata[31:30], 0);
                if (m_axis_tuser[0] !== w.level)
                    report_mismatch("level_flag", m_axis_tuser[0], w.level);
            end
        end
        m_axis_tready <= rst_n && !hold_output && $urandom_range(0, 99) >= recv_idle_pct;
    end

    task automatic wait_drained();
        while (pending_angles.size() > 0 || s_axis_tvalid || expected_tilts.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int holdoff;
        logic signed [15:0] edges[10] = '{0, 1, -1, 23040, -23040, 11520, -11520,
                                          16'sh7FFF, 16'sh8000, 5760};
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_output = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 15;
        recv_idle_pct = 52;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_angles(0, 0);
        queue_angles(23040, 0);
        queue_angles(0, -23040);
        queue_angles(-23040, 23040);
        for (int i = 0; i < 20; i++)
            queue_angles(edges[$urandom_range(0, 9)], edges[$urandom_range(0, 9)]);
        queue_angles(16'sh5555, 16'shAAAA);
        for (int i = 0; i < 500; i++)
            queue_angles(random_angle(), random_angle());
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 15;
        for (int i = 0; i < 500; i++)
            queue_angles(random_angle(), random_angle());
        hold_output = 1'b1;
        holdoff = 0;
        while (holdoff < 3 * LATENCY)
        begin
            @(posedge clk);
            holdoff++;
        end
        hold_output = 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 525; i++)
            queue_angles(random_angle(), random_angle());
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);

        if (mismatches == 0 && expected_tilts.size() == 0)
            $display("tilt_from_pitch_roll verification clean");
        else
            $display("tilt_from_pitch_roll verification failed");
        $finish;
    end

endmodule
